// File: rtl/core/buddy_block_allocator_defines.svh
// Assertion macros for the buddy block allocator.
// No dependencies; included by the files that carry assertions.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");
// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/bba_pkg.sv
// Shared types, request codes and a helper function of the buddy block allocator.
// No dependencies.
package bba_pkg;

   // Request codes.
   localparam logic [1:0] REQ_INIT   = 2'd0;
   localparam logic [1:0] REQ_ALLOC  = 2'd1;
   localparam logic [1:0] REQ_FREE   = 2'd2;
   localparam logic [1:0] REQ_STATUS = 2'd3;

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BASE = 1'b0;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] block_address;
      logic [31:0] request_size;
   } bba_request_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic        success;
      logic [31:0] free_bytes;
   } bba_result_type;

   // Log2 of the size rounded up to a power of two; a size of zero gives 32.
   function automatic logic [5:0] ceil_order(input logic [31:0] v);
      logic [31:0] m;
      logic [5:0]  o;
      m = v - 32'd1;
      o = 6'd0;
      for (int i = 0; i < 32; i++) begin
         if (m[i]) o = 6'(i + 1);
      end
      return (v == 32'd0) ? 6'd32 : o;
   endfunction

endpackage

// File: rtl/core/bba_channels_if.sv
// Valid/ready channel interfaces for request and result words.
// No dependencies.
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] block_address;
   logic [31:0] request_size;
   modport source(output valid, req_type, block_address, request_size, input ready);
   modport sink(input valid, req_type, block_address, request_size, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_address;
   logic        success;
   logic [31:0] free_bytes;
   modport source(output valid, result_address, success, free_bytes, input ready);
   modport sink(input valid, result_address, success, free_bytes, output ready);
endinterface

// File: rtl/core/bba_link_ram.sv
// Single-port-write, single-port-read link memory with a registered read.
// No dependencies.
module bba_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the entry being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bba_engine.sv
// Request sequencer of the buddy block allocator: list heads in flops,
// next links in bba_link_ram. Uses bba_pkg.
module bba_engine #(
   parameter int SMALLEST_ORDER = 12,
   parameter int TOP_ORDER      = 22,
   parameter int POOL_BLOCKS    = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bba_pkg::bba_request_type req,
   input  logic [31:0]             base_address,
   input  logic                    out_free,
   output logic                    idle,
   output logic                    done,
   output bba_pkg::bba_result_type result
);

   localparam int NUM_ORDERS = TOP_ORDER - SMALLEST_ORDER;
   localparam int LW = $clog2(POOL_BLOCKS + 1);
   localparam int AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
   localparam int KW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
   localparam logic [LW-1:0] NO_BLOCK = LW'(POOL_BLOCKS);
   localparam logic [KW-1:0] K_LAST = KW'(NUM_ORDERS - 1);
   localparam logic [63:0] POOL_BYTES = 64'(POOL_BLOCKS) << SMALLEST_ORDER;
   localparam logic [31:0] UNIT_BYTES = 32'd1 << SMALLEST_ORDER;
   localparam logic [5:0] ORD_MIN = 6'(SMALLEST_ORDER);
   localparam logic [5:0] ORD_TOP = 6'(TOP_ORDER);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INIT      = 4'd1;
   localparam logic [3:0] S_AL_POP    = 4'd2;
   localparam logic [3:0] S_AL_SPLIT  = 4'd3;
   localparam logic [3:0] S_REL_START = 4'd4;
   localparam logic [3:0] S_REL_WALK  = 4'd5;
   localparam logic [3:0] S_ST_HEAD   = 4'd6;
   localparam logic [3:0] S_ST_WALK   = 4'd7;
   localparam logic [3:0] S_FINISH    = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] heads_ff [NUM_ORDERS];
   logic [LW-1:0] heads_in [NUM_ORDERS];
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] want_ff, want_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic [LW-1:0] units_ff, units_in;
   logic          rem_ff, rem_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   addr_ff, addr_in;
   logic          ok_ff, ok_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [LW-1:0] ram_wdata, ram_rdata;

   bba_link_ram #(.DEPTH(POOL_BLOCKS), .WIDTH(LW)) u_links (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Request decode: clamped order, free checks, init clamp.
   logic [5:0]    raw_ord, req_ord;
   logic [KW-1:0] req_k;
   logic [31:0]   free_off, free_idx, free_span;
   logic          free_ok;
   logic          init_big;
   logic [LW-1:0] init_units;
   logic          init_rem;

   assign raw_ord  = bba_pkg::ceil_order(req.request_size);
   assign req_ord  = (raw_ord < ORD_MIN) ? ORD_MIN : raw_ord;
   assign req_k    = KW'(req_ord - ORD_MIN);
   assign free_off = req.block_address - base_address;
   assign free_idx = free_off >> SMALLEST_ORDER;
   assign free_span = 32'd1 << (req_ord - ORD_MIN);
   assign free_ok  = (req_ord < ORD_TOP) && (free_off[SMALLEST_ORDER-1:0] == '0) &&
                     ((free_idx & (free_span - 32'd1)) == 32'd0) &&
                     (({1'b0, free_idx} + {1'b0, free_span}) <= 33'(POOL_BLOCKS));
   assign init_big   = {32'd0, req.request_size} > POOL_BYTES;
   assign init_units = init_big ? NO_BLOCK : LW'(req.request_size >> SMALLEST_ORDER);
   assign init_rem   = !init_big && (req.request_size[SMALLEST_ORDER-1:0] != '0);

   // First non-empty list at or above the wanted order.
   logic          al_found;
   logic [KW-1:0] al_k;
   always_comb begin
      al_found = 1'b0;
      al_k     = '0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if ((KW'(i) >= req_k) && (heads_ff[i] != NO_BLOCK)) begin
            al_found = 1'b1;
            al_k     = KW'(i);
         end
      end
   end

   // Largest block order that the remaining pool still covers.
   logic [KW-1:0] init_j;
   logic          init_cont;
   always_comb begin
      init_j = '0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
         if (32'(units_ff) >= (32'd1 << i)) init_j = KW'(i);
      end
   end
   assign init_cont = (units_ff > LW'(1)) || ((units_ff == LW'(1)) && rem_ff);

   // One list head read, selected by state.
   logic [KW-1:0] k_dn, head_sel;
   logic [LW-1:0] head_rd;
   assign k_dn = k_ff - KW'(1);
   always_comb begin
      case (state_ff)
         S_INIT:     head_sel = init_j;
         S_AL_SPLIT: head_sel = k_dn;
         default:    head_sel = k_ff;
      endcase
   end
   assign head_rd = heads_ff[head_sel];

   // Upper half split off the popped block at the next order down.
   logic [LW-1:0] split_idx;
   assign split_idx = head_ff + (LW'(1) << k_dn);

   // Link walk helpers.
   logic [LW-1:0] link_nx, lo, hi;
   logic          buddy_hit;
   logic [31:0]   blk_bytes;
   logic [32:0]   acc_sum;
   logic [31:0]   acc_add;
   assign link_nx   = (ram_rdata >= NO_BLOCK) ? NO_BLOCK : ram_rdata;
   assign lo        = (head_ff < idx_ff) ? head_ff : idx_ff;
   assign hi        = (head_ff < idx_ff) ? idx_ff : head_ff;
   assign buddy_hit = (k_ff != K_LAST) && ((32'(lo) ^ (32'd1 << k_ff)) == 32'(hi));
   assign blk_bytes = 32'd1 << (32'(k_ff) + SMALLEST_ORDER);
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, blk_bytes};
   assign acc_add   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      heads_in = heads_ff;
      k_in     = k_ff;
      want_in  = want_ff;
      idx_in   = idx_ff;
      head_in  = head_ff;
      prev_in  = prev_ff;
      steps_in = steps_ff;
      units_in = units_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      addr_in  = addr_ff;
      ok_in    = ok_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = NO_BLOCK;
      ram_raddr = head_ff[AW-1:0];
      done      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in  = 32'd0;
               ok_in    = 1'b1;
               acc_in   = 32'd0;
               state_in = S_FINISH;
               case (req.req_type)
                  bba_pkg::REQ_INIT: begin
                     if (req.request_size <= UNIT_BYTES) begin
                        ok_in = 1'b0;
                     end else begin
                        for (int i = 0; i < NUM_ORDERS; i++) heads_in[i] = NO_BLOCK;
                        units_in = init_units;
                        rem_in   = init_rem;
                        pos_in   = '0;
                        state_in = S_INIT;
                     end
                  end
                  bba_pkg::REQ_ALLOC: begin
                     if ((req_ord < ORD_TOP) && al_found) begin
                        k_in      = al_k;
                        want_in   = req_k;
                        head_in   = heads_ff[al_k];
                        ram_raddr = heads_ff[al_k][AW-1:0];
                        state_in  = S_AL_POP;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  bba_pkg::REQ_FREE: begin
                     if (free_ok) begin
                        idx_in   = LW'(free_idx);
                        k_in     = req_k;
                        state_in = S_REL_START;
                     end
                  end
                  default: begin
                     k_in     = '0;
                     state_in = S_ST_HEAD;
                  end
               endcase
            end
         end
         // Greedy split of the pool, one block a cycle.
         S_INIT: begin
            if (!init_cont) begin
               state_in = S_FINISH;
            end else begin
               ram_we           = 1'b1;
               ram_waddr        = pos_ff[AW-1:0];
               ram_wdata        = head_rd;
               heads_in[init_j] = pos_ff;
               pos_in           = pos_ff + (LW'(1) << init_j);
               units_in         = units_ff - (LW'(1) << init_j);
            end
         end
         // Pop the head once its link is back.
         S_AL_POP: begin
            heads_in[k_ff] = link_nx;
            addr_in        = base_address + (32'(head_ff) << SMALLEST_ORDER);
            state_in       = (k_ff == want_ff) ? S_FINISH : S_AL_SPLIT;
         end
         // Push the upper half at each order on the way down.
         S_AL_SPLIT: begin
            ram_we         = 1'b1;
            ram_waddr      = split_idx[AW-1:0];
            ram_wdata      = head_rd;
            heads_in[k_dn] = split_idx;
            k_in           = k_dn;
            if (k_dn == want_ff) state_in = S_FINISH;
         end
         // Terminate the freed block and start the buddy search.
         S_REL_START: begin
            ram_we = 1'b1;
            if (head_rd == NO_BLOCK) begin
               heads_in[k_ff] = idx_ff;
               state_in       = S_FINISH;
            end else begin
               head_in   = head_rd;
               prev_in   = NO_BLOCK;
               steps_in  = '0;
               ram_raddr = head_rd[AW-1:0];
               state_in  = S_REL_WALK;
            end
         end
         // One list entry a cycle: merge, append, step on or stop at the step limit.
         S_REL_WALK: begin
            if (buddy_hit) begin
               if (prev_ff != NO_BLOCK) begin
                  ram_we    = 1'b1;
                  ram_waddr = prev_ff[AW-1:0];
                  ram_wdata = link_nx;
               end else begin
                  heads_in[k_ff] = link_nx;
               end
               idx_in   = lo;
               k_in     = k_ff + KW'(1);
               state_in = S_REL_START;
            end else if (link_nx == NO_BLOCK) begin
               ram_we    = 1'b1;
               ram_waddr = head_ff[AW-1:0];
               ram_wdata = idx_ff;
               state_in  = S_FINISH;
            end else if (steps_ff == LW'(POOL_BLOCKS - 1)) begin
               state_in = S_FINISH;
            end else begin
               prev_in   = head_ff;
               head_in   = link_nx;
               steps_in  = steps_ff + LW'(1);
               ram_raddr = link_nx[AW-1:0];
            end
         end
         // Free byte count: list heads.
         S_ST_HEAD: begin
            if (head_rd != NO_BLOCK) begin
               acc_in    = acc_add;
               steps_in  = LW'(1);
               ram_raddr = head_rd[AW-1:0];
               state_in  = S_ST_WALK;
            end else if (k_ff == K_LAST) begin
               state_in = S_FINISH;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         // Free byte count: list bodies.
         S_ST_WALK: begin
            if ((link_nx != NO_BLOCK) && (steps_ff < NO_BLOCK)) begin
               acc_in    = acc_add;
               steps_in  = steps_ff + LW'(1);
               ram_raddr = link_nx[AW-1:0];
            end else if (k_ff == K_LAST) begin
               state_in = S_FINISH;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_ST_HEAD;
            end
         end
         // Hand the result word over once the output slot is free.
         S_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_ORDERS; i++) heads_ff[i] <= NO_BLOCK;
      end else begin
         state_ff <= state_in;
         heads_ff <= heads_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      want_ff  <= want_in;
      idx_ff   <= idx_in;
      head_ff  <= head_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      units_ff <= units_in;
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      acc_ff   <= acc_in;
      addr_ff  <= addr_in;
      ok_ff    <= ok_in;
   end

   assign idle                  = (state_ff == S_IDLE);
   assign result.result_address = addr_ff;
   assign result.success        = ok_ff;
   assign result.free_bytes     = acc_ff;

endmodule

// File: rtl/core/buddy_block_allocator.sv
// Top level of the buddy block allocator: channels, register port, result register.
// Uses bba_pkg, bba_channels_if, bba_engine and buddy_block_allocator_defines.svh.
//
//   channel   direction  handshake        contents
//   req_bus   in         valid/ready      req_type, block_address, request_size
//   rsp_bus   out        valid/ready      result_address, success, free_bytes
//   csr_*     in/out     APB, pready = 1  base_address at byte address 0
//
// One request at a time. Init creates its blocks in turn; alloc splits
// down through the orders in turn; free walks a list for each order merged;
// status walks every order's list and counts its free blocks. The registered
// link memory read paces every list walk.
// Reset is synchronous and empties all lists; no clearing pass is needed.
// A finished result waits in the output register, and the next request is
// taken meanwhile; it stalls only at its own end if that register is still full.
module buddy_block_allocator #(
   parameter int SMALLEST_ORDER = 12,
   parameter int TOP_ORDER      = 22,
   parameter int POOL_BLOCKS    = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   bba_req_if.sink                        req_bus,
   bba_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

`include "buddy_block_allocator_defines.svh"

   logic [31:0]              base_ff;
   logic                     rsp_valid_ff;
   bba_pkg::bba_result_type  rsp_word_ff;
   bba_pkg::bba_request_type req_word;
   bba_pkg::bba_result_type  eng_result;
   logic                     eng_idle, eng_done, req_fire, out_free;

   // Base address register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bba_pkg::CSR_IDX_BASE) ? base_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == bba_pkg::CSR_IDX_BASE)) begin
         base_ff <= csr_pwdata;
      end
   end

   // Request channel.
   assign req_bus.ready          = eng_idle;
   assign req_fire               = req_bus.valid && eng_idle;
   assign req_word.req_type      = req_bus.req_type;
   assign req_word.block_address = req_bus.block_address;
   assign req_word.request_size  = req_bus.request_size;
   assign out_free               = !rsp_valid_ff || rsp_bus.ready;

   bba_engine #(
      .SMALLEST_ORDER (SMALLEST_ORDER),
      .TOP_ORDER      (TOP_ORDER),
      .POOL_BLOCKS    (POOL_BLOCKS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (req_fire),
      .req          (req_word),
      .base_address (base_ff),
      .out_free     (out_free),
      .idle         (eng_idle),
      .done         (eng_done),
      .result       (eng_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (eng_done) rsp_word_ff <= eng_result;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_address = rsp_word_ff.result_address;
   assign rsp_bus.success        = rsp_word_ff.success;
   assign rsp_bus.free_bytes     = rsp_word_ff.free_bytes;

   // Checks.
   `BBA_ASSERT_NEXT(a_start_busy, clock, reset, req_fire, !req_bus.ready)
   `BBA_ASSERT_NEXT(a_done_loads, clock, reset, eng_done, rsp_valid_ff)
   `BBA_ASSERT_IMPL(a_no_overrun, clock, reset, eng_done, !rsp_valid_ff || rsp_bus.ready)
   `BBA_ASSERT_IMPL(a_fail_no_addr, clock, reset, rsp_valid_ff, rsp_word_ff.success || (rsp_word_ff.result_address == 32'd0))

endmodule
